// ===== sv/bwf_pkg.sv =====
// Shared constants, types and kernel tables of the bilateral window filter.
package bwf_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_RADIUS    = 5;
    localparam int MAX_HEIGHT    = 4096;
    localparam int WIN_SIDE      = 2 * MAX_RADIUS + 1;
    localparam int LINE_DEPTH    = WIN_SIDE * MAX_WIDTH;
    localparam int ADDR_W        = $clog2(LINE_DEPTH);
    localparam int PIX_W         = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int TIDX_W        = 8;
    localparam int KWT_W         = 6;
    localparam int WT_W          = KWT_W + PIX_W;
    localparam int PROD_W        = WT_W + PIX_W;
    localparam int NUM_W         = 46;
    localparam int DEN_W         = 29;
    localparam int Q_W           = 16;
    localparam int NUM_KERNELS   = 22;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL = 2'd2;
    localparam logic [1:0] REG_SHIFT  = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   dvd;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quot;
    } t_div_lane;

    localparam logic [2:0] KERN_RAD [NUM_KERNELS] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // quadrant [rad-|dy|][rad-|dx|] of each kernel, zero padded
    localparam logic [KWT_W-1:0] KERN_QUAD [NUM_KERNELS][6][6] = '{
        '{'{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0},
          '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{1,7,0,0,0,0},'{7,55,0,0,0,0},'{0,0,0,0,0,0},
          '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{1,4,0,0,0,0},'{4,16,0,0,0,0},'{0,0,0,0,0,0},
          '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,0,0,0},'{0,8,21,0,0,0},'{1,21,59,0,0,0},
          '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,0,0,0},'{0,5,10,0,0,0},'{1,10,23,0,0,0},
          '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,1,2,0,0,0},'{1,6,12,0,0,0},'{2,12,22,0,0,0},
          '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,1,2,0,0,0},'{1,4,7,0,0,0},'{2,7,12,0,0,0},
          '{0,0,0,0,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,1,0,0},'{0,2,5,8,0,0},'{1,5,18,27,0,0},
          '{1,8,27,41,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,1,0,0},'{0,1,4,6,0,0},'{1,4,11,16,0,0},
          '{1,6,16,23,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,1,0,0},'{0,2,4,6,0,0},'{1,4,11,14,0,0},
          '{1,6,14,19,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,1,2,3,0,0},'{1,4,8,10,0,0},'{2,8,17,21,0,0},
          '{3,10,21,28,0,0},'{0,0,0,0,0,0},'{0,0,0,0,0,0}},
        '{'{0,0,0,1,1,0},'{0,1,2,4,5,0},'{0,2,6,12,14,0},
          '{1,4,12,22,28,0},'{1,5,14,28,35,0},'{0,0,0,0,0,0}},
        '{'{0,0,0,1,1,0},'{0,1,2,3,4,0},'{0,2,5,9,10,0},
          '{1,3,9,15,19,0},'{1,4,10,19,23,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,1,1,0},'{0,1,2,3,4,0},'{1,2,5,8,9,0},
          '{1,3,8,13,16,0},'{1,4,9,16,19,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,2,2,0},'{0,1,3,5,5,0},'{1,3,6,10,12,0},
          '{2,5,10,16,19,0},'{2,5,12,19,22,0},'{0,0,0,0,0,0}},
        '{'{0,0,1,2,2,0},'{0,1,3,4,5,0},'{1,3,5,8,9,0},
          '{2,4,8,12,14,0},'{2,5,9,14,16,0},'{0,0,0,0,0,0}},
        '{'{0,0,0,1,1,1},'{0,0,1,2,3,3},'{0,1,2,4,7,7},
          '{1,2,4,8,12,14},'{1,3,7,12,18,20},'{1,3,7,14,20,23}},
        '{'{0,0,0,1,1,1},'{0,0,1,2,3,3},'{0,1,2,4,6,7},
          '{1,2,4,8,11,12},'{1,3,6,11,15,17},'{1,3,7,12,17,19}},
        '{'{0,0,0,1,1,2},'{0,1,2,3,3,4},'{1,2,3,5,7,8},
          '{1,3,5,9,12,13},'{1,3,7,12,16,18},'{2,4,8,13,18,20}},
        '{'{0,0,1,1,1,1},'{0,1,1,2,3,3},'{1,1,3,5,6,7},
          '{1,2,5,7,10,11},'{1,3,6,10,13,14},'{1,3,7,11,14,16}},
        '{'{0,0,1,1,1,1},'{0,1,1,2,3,3},'{1,1,3,4,5,6},
          '{1,2,4,6,8,9},'{1,3,5,8,10,11},'{1,3,6,9,11,12}},
        '{'{0,0,1,1,1,1},'{0,1,1,2,3,3},'{1,1,2,4,5,5},
          '{1,2,4,5,7,7},'{1,3,5,7,9,9},'{1,3,5,7,9,10}}
    };

    function automatic logic [2:0] kern_radius(input logic [4:0] ks);
        logic [2:0] rad;
        rad = 3'd0;
        if (ks < 5'(NUM_KERNELS)) begin
            rad = KERN_RAD[ks];
        end
        return rad;
    endfunction

    function automatic logic [KWT_W-1:0] kern_weight(input logic [4:0] ks,
                                                     input logic [2:0] qy,
                                                     input logic [2:0] qx);
        logic [KWT_W-1:0] wt;
        wt = '0;
        if (ks < 5'(NUM_KERNELS) && qy < 3'd6 && qx < 3'd6) begin
            wt = KERN_QUAD[ks][qy][qx];
        end
        return wt;
    endfunction

endpackage

// ===== sv/bwf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/bwf_div_cell.sv =====
// One restoring-division cell: brings in one dividend bit, yields one quotient bit.
module bwf_div_cell
    import bwf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);
    logic [DEN_W:0]   trial;
    logic             take;
    t_div_lane        r_lane;

    assign trial = {i_lane.rem, i_lane.dvd[Q_W-1]};
    assign take  = trial >= {1'b0, i_lane.den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= i_lane.valid;
        end
        r_lane.rem  <= take ? DEN_W'(trial - {1'b0, i_lane.den}) : trial[DEN_W-1:0];
        r_lane.dvd  <= {i_lane.dvd[Q_W-2:0], 1'b0};
        r_lane.den  <= i_lane.den;
        r_lane.quot <= {i_lane.quot[Q_W-2:0], take};
    end

    assign o_lane = r_lane;
endmodule

// ===== sv/bwf_divider.sv =====
// Chain of division cells computing the weighted-average quotient.
module bwf_divider
    import bwf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot
);
    t_div_lane lane [Q_W+1];

    // quotient fits Q_W bits, so the upper dividend bits start below the divisor
    assign lane[0].valid = i_valid;
    assign lane[0].rem   = i_dividend[DEN_W+Q_W-1:Q_W];
    assign lane[0].dvd   = i_dividend[Q_W-1:0];
    assign lane[0].den   = i_den;
    assign lane[0].quot  = '0;

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        bwf_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_lane (lane[g]),
            .o_lane (lane[g+1])
        );
    end

    assign o_valid = lane[Q_W].valid;
    assign o_quot  = lane[Q_W].quot;
endmodule

// ===== sv/bilateral_window_filter_top.sv =====
// Bilateral window filter: line store, window sequencer, weighted MAC and divider chain.
// A pass-through or border pixel passes S_CENTRE and S_CCAP, then S_OUT; a filtered pixel
// also walks the window in S_WIN, one line-store read per tap, drains the MAC in S_DRAIN
// and runs the 16-cell divider chain in S_DIV. Items that cause no result stay in S_IDLE.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Synchronous active-low reset clears control state; no clearing pass over the memories.
module bilateral_window_filter_top
    import bwf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [PIX_W-1:0]  i_pixel_value,
    input  logic [TIDX_W-1:0] i_table_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PIX_W-1:0]  o_filtered_pixel,
    output logic              o_last_of_frame,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    typedef enum logic [2:0] {
        S_IDLE, S_CENTRE, S_CCAP, S_WIN, S_DRAIN, S_DIV, S_OUT
    } t_state;

    t_state            r_state;
    logic [12:0]       r_width, r_height;
    logic [4:0]        r_kernel;
    logic [3:0]        r_shift;
    logic [11:0]       r_in_col, r_out_col;
    logic [12:0]       r_in_row, r_out_row;
    logic [23:0]       r_in_count, r_out_cnt;
    logic [ADDR_W-1:0] r_wptr, r_kptr, r_addr, r_row_addr;
    logic [3:0]        r_dx, r_dy;
    logic [2:0]        r_rad;
    logic [PIX_W-1:0]  r_centre, r_res;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic              r_out_valid, r_last;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_v1, r_v2, r_v3, r_v4;
    logic [KWT_W-1:0]  r_ws1, r_ws2;
    logic [PIX_W-1:0]  r_p2, r_p3;
    logic [WT_W-1:0]   r_wt3, r_wt4;
    logic [PROD_W-1:0] r_prod4;

    logic [12:0]       w_eff, h_eff;
    logic [24:0]       total;
    logic [15:0]       delay;
    logic              busy, cfg_we, accept, draining;
    logic              line_we;
    logic [ADDR_W-1:0] line_raddr, off, base;
    logic [PIX_W-1:0]  line_rdata, tbl_rdata, adiff, sdiff;
    logic [TIDX_W-1:0] tbl_raddr;
    logic [2:0]        rad_c, qy, qx;
    logic [3:0]        side_m1, ady, adx;
    logic              interior, v0;
    logic [KWT_W-1:0]  ws0;
    logic [ADDR_W:0]   row_sum;
    logic [ADDR_W-1:0] row_next, addr_next;
    logic              div_valid;
    logic [Q_W-1:0]    div_quot;
    logic [NUM_W-1:0]  dividend;
    logic [24:0]       k_next;

    assign w_eff = (r_width == '0) ? 13'd1 :
                   (r_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : r_width;
    assign h_eff = (r_height == '0) ? 13'd1 :
                   (r_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : r_height;
    assign total = 25'(w_eff) * 25'(h_eff);
    assign delay = 16'(w_eff) * 16'(MAX_RADIUS) + 16'(MAX_RADIUS);
    assign busy  = (r_in_row != '0) || (r_in_col != '0) || (r_out_cnt != '0);
    assign draining = r_in_row >= h_eff;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_KERNEL: prdata = 32'(r_kernel);
            REG_SHIFT:  prdata = 32'(r_shift);
            default:    prdata = '0;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign line_we    = accept && (i_mode == MODE_PIXEL) && !draining;

    // window geometry of the pixel being emitted
    assign rad_c    = kern_radius(r_kernel);
    assign interior = (rad_c != '0) && (r_out_row >= 13'(rad_c))
                   && (14'(r_out_row) + 14'(rad_c) < 14'(h_eff))
                   && (r_out_col >= 12'(rad_c))
                   && (13'(r_out_col) + 13'(rad_c) < w_eff);
    assign off  = ADDR_W'(rad_c) * ADDR_W'(w_eff) + ADDR_W'(rad_c);
    assign base = (r_kptr >= off) ? (r_kptr - off)
                                  : (r_kptr + (ADDR_W'(LINE_DEPTH) - off));

    assign side_m1 = {r_rad, 1'b0};
    assign ady = (r_dy > 4'(r_rad)) ? (r_dy - 4'(r_rad)) : (4'(r_rad) - r_dy);
    assign adx = (r_dx > 4'(r_rad)) ? (r_dx - 4'(r_rad)) : (4'(r_rad) - r_dx);
    assign qy  = r_rad - ady[2:0];
    assign qx  = r_rad - adx[2:0];
    assign v0  = (r_state == S_WIN);
    assign ws0 = kern_weight(r_kernel, qy, qx);

    assign row_sum   = {1'b0, r_row_addr} + (ADDR_W+1)'(w_eff);
    assign row_next  = (row_sum >= (ADDR_W+1)'(LINE_DEPTH))
                     ? ADDR_W'(row_sum - (ADDR_W+1)'(LINE_DEPTH)) : row_sum[ADDR_W-1:0];
    assign addr_next = (r_addr == ADDR_W'(LINE_DEPTH - 1)) ? '0 : r_addr + 1'b1;

    assign line_raddr = (r_state == S_CENTRE) ? r_kptr : r_addr;

    bwf_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk  (i_clk),
        .i_we   (line_we),
        .i_waddr(r_wptr),
        .i_wdata(i_pixel_value),
        .i_raddr(line_raddr),
        .o_rdata(line_rdata)
    );

    assign adiff     = (line_rdata > r_centre) ? (line_rdata - r_centre)
                                               : (r_centre - line_rdata);
    assign sdiff     = adiff >> r_shift;
    assign tbl_raddr = (sdiff > PIX_W'(TABLE_ENTRIES - 1)) ? TIDX_W'(TABLE_ENTRIES - 1)
                                                          : sdiff[TIDX_W-1:0];

    bwf_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk  (i_clk),
        .i_we   (accept && (i_mode == MODE_LOAD)),
        .i_waddr(i_table_index),
        .i_wdata(i_pixel_value),
        .i_raddr(tbl_raddr),
        .o_rdata(tbl_rdata)
    );

    assign dividend = r_num + NUM_W'(r_den >> 1);

    bwf_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   ((r_state == S_DRAIN) && !(r_v1 || r_v2 || r_v3 || r_v4)),
        .i_dividend(dividend),
        .i_den     (r_den),
        .o_valid   (div_valid),
        .o_quot    (div_quot)
    );

    assign k_next = 25'(r_out_cnt) + 25'd1;

    // weighted multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_ws1   <= ws0;
        r_ws2   <= r_ws1;
        r_p2    <= line_rdata;
        r_wt3   <= WT_W'(r_ws2) * WT_W'(tbl_rdata);
        r_p3    <= r_p2;
        r_prod4 <= PROD_W'(r_wt3) * PROD_W'(r_p3);
        r_wt4   <= r_wt3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= 13'd640;
            r_height    <= 13'd480;
            r_kernel    <= 5'd0;
            r_shift     <= 4'd8;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_count  <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_cnt   <= '0;
            r_wptr      <= '0;
            r_kptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (paddr[3:2])
                    REG_WIDTH:  if (!busy) r_width <= pwdata[12:0];
                    REG_HEIGHT: if (!busy) r_height <= pwdata[12:0];
                    REG_KERNEL: r_kernel <= pwdata[4:0];
                    REG_SHIFT:  r_shift <= pwdata[3:0];
                    default:    ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_v4) begin
                r_num <= r_num + NUM_W'(r_prod4);
                r_den <= r_den + DEN_W'(r_wt4);
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_mode == MODE_PIXEL && !draining) begin
                        r_wptr     <= (r_wptr == ADDR_W'(LINE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                        r_in_count <= r_in_count + 1'b1;
                        if (13'(r_in_col) + 13'd1 >= w_eff) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + 1'b1;
                        end else begin
                            r_in_col <= r_in_col + 1'b1;
                        end
                        if (r_in_count >= 24'(delay)) begin
                            r_state <= S_CENTRE;
                        end
                    end else if (accept && i_mode == MODE_FLUSH && draining) begin
                        r_state <= S_CENTRE;
                    end
                end
                S_CENTRE: begin
                    r_state <= S_CCAP;
                end
                S_CCAP: begin
                    r_centre   <= line_rdata;
                    r_res      <= line_rdata;
                    r_rad      <= rad_c;
                    r_addr     <= base;
                    r_row_addr <= base;
                    r_dx       <= '0;
                    r_dy       <= '0;
                    r_num      <= '0;
                    r_den      <= '0;
                    r_state    <= interior ? S_WIN : S_OUT;
                end
                S_WIN: begin
                    if (r_dx == side_m1) begin
                        r_dx       <= '0;
                        r_dy       <= r_dy + 1'b1;
                        r_row_addr <= row_next;
                        r_addr     <= row_next;
                        if (r_dy == side_m1) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_dx   <= r_dx + 1'b1;
                        r_addr <= addr_next;
                    end
                end
                S_DRAIN: begin
                    if (!(r_v1 || r_v2 || r_v3 || r_v4)) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_valid) begin
                        if (r_den != '0) begin
                            r_res <= div_quot;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pix   <= r_res;
                        r_last      <= (k_next == total);
                        r_state     <= S_IDLE;
                        if (k_next >= total) begin
                            // frame done: rewind the frame counters and the write and kernel pointers
                            r_out_cnt  <= '0;
                            r_out_col  <= '0;
                            r_out_row  <= '0;
                            r_in_col   <= '0;
                            r_in_row   <= '0;
                            r_in_count <= '0;
                            r_wptr     <= '0;
                            r_kptr     <= '0;
                        end else begin
                            r_out_cnt <= k_next[23:0];
                            r_kptr <= (r_kptr == ADDR_W'(LINE_DEPTH - 1)) ? '0 : r_kptr + 1'b1;
                            if (13'(r_out_col) + 13'd1 >= w_eff) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + 1'b1;
                            end else begin
                                r_out_col <= r_out_col + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_pixel = r_out_pix;
    assign o_last_of_frame  = r_last;

`ifndef SYNTHESIS
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_we |-> (r_state == S_IDLE))
        else $error("line store written outside idle");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_valid |-> (r_state == S_DIV))
        else $error("divider result with no window pending");
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        25'(r_out_cnt) < total)
        else $error("output count beyond frame size");
`endif
endmodule

// ===== sim/bilateral_window_filter_top_tb.sv =====
// Self-checking testbench for the bilateral window filter top level.
module bilateral_window_filter_top_tb;
    import bwf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 200;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_pixel_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_mode = MODE_LOAD;
    logic [PIX_W-1:0]  i_pixel_value = '0;
    logic [TIDX_W-1:0] i_table_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [PIX_W-1:0]  o_filtered_pixel;
    logic              o_last_of_frame;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    bilateral_window_filter_top uut (.*);

    // filter state mirror
    logic [PIX_W-1:0] pix_lines [LINE_DEPTH];
    logic [PIX_W-1:0] range_lut [TABLE_ENTRIES];
    int unsigned      cfg_width, cfg_height, cfg_kernel, cfg_shift;
    int unsigned      in_col, in_row, out_cnt;

    t_pixel_result    pending_pixels[$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               items_sent = 0;
    t_idle_mode       idle_mode = IDLE_NONE;
    int               hold_off = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bilateral_window_filter_top regression: fail");
            $finish;
        end
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    endfunction

    function automatic void emit_pixel();
        int unsigned w, h, k, r, c, rad, base, p, ti, qy, qx;
        logic [63:0] num, den, wt;
        logic [31:0] res;
        t_pixel_result item;
        w = eff_width();
        h = eff_height();
        k = out_cnt;
        r = k / w;
        c = k % w;
        res = pix_lines[k % LINE_DEPTH];
        rad = (cfg_kernel < NUM_KERNELS) ? KERN_RAD[cfg_kernel] : 0;
        if (rad > MAX_RADIUS) rad = 0;
        if (rad != 0 && r >= rad && r + rad < h && c >= rad && c + rad < w) begin
            base = k - rad * w - rad;
            num = 0;
            den = 0;
            for (int dy = 0; dy <= 2 * rad; dy++) begin
                for (int dx = 0; dx <= 2 * rad; dx++) begin
                    p = pix_lines[(base + dy * w + dx) % LINE_DEPTH];
                    qy = rad - ((dy > rad) ? dy - rad : rad - dy);
                    qx = rad - ((dx > rad) ? dx - rad : rad - dx);
                    ti = ((p > res) ? p - res : res - p) >> cfg_shift;
                    if (ti > TABLE_ENTRIES - 1) ti = TABLE_ENTRIES - 1;
                    wt = 64'(KERN_QUAD[cfg_kernel][qy][qx]) * 64'(range_lut[ti]);
                    num += wt * p;
                    den += wt;
                end
            end
            if (den != 0) res = 32'((num + den / 2) / den);
        end
        item.pixel = res[PIX_W-1:0];
        item.last = (k + 1 == w * h);
        pending_pixels.push_back(item);
        out_cnt = k + 1;
        if (out_cnt >= w * h) begin
            out_cnt = 0;
            in_row = 0;
            in_col = 0;
        end
    endfunction

    function automatic void filter_model_item(logic [1:0] mode, logic [15:0] val,
                                              logic [7:0] idx);
        int unsigned w, n;
        bit draining;
        w = eff_width();
        draining = in_row >= eff_height();
        case (mode)
            MODE_LOAD: range_lut[idx] = val;
            MODE_PIXEL: begin
                if (!draining) begin
                    n = in_row * w + in_col;
                    pix_lines[n % LINE_DEPTH] = val;
                    in_col++;
                    if (in_col >= w) begin
                        in_col = 0;
                        in_row++;
                    end
                    if (n >= MAX_RADIUS * w + MAX_RADIUS) emit_pixel();
                end
            end
            MODE_FLUSH: if (draining) emit_pixel();
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [1:0] mode, logic [15:0] val, logic [7:0] idx);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 62 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_pixel_value <= val;
        i_table_index <= idx;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        filter_model_item(mode, val, idx);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        bit busy;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        busy = in_row != 0 || in_col != 0 || out_cnt != 0;
        case (index)
            REG_WIDTH:  if (!busy) cfg_width = value[12:0];
            REG_HEIGHT: if (!busy) cfg_height = value[12:0];
            REG_KERNEL: cfg_kernel = value[4:0];
            REG_SHIFT:  cfg_shift = value[3:0];
            default: ;
        endcase
    endtask

    // hold stimulus until every predicted pixel has come out, then let the block settle
    task automatic drain();
        release_input();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    always @(negedge i_clk) begin
        int pct;
        pct = (idle_mode == IDLE_RECEIVER) ? 62 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected item", o_filtered_pixel, -1);
            end else begin
                want = pending_pixels.pop_front();
                if (o_filtered_pixel !== want.pixel)
                    report_mismatch("filtered_pixel", o_filtered_pixel, want.pixel);
                if (o_last_of_frame !== want.last)
                    report_mismatch("last_of_frame", o_last_of_frame, want.last);
            end
        end
    end

    function automatic logic [15:0] pick_pixel(int style, logic [15:0] base);
        case (style)
            0: return 16'($urandom);
            1: return base + 16'($urandom_range(0, 255));
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // push out whatever the frame still owes, with some dropped pixels mixed in
    task automatic flush_frame();
        while (in_row >= eff_height()) begin
            if ($urandom_range(9) == 0) send_item(MODE_PIXEL, 16'($urandom), '0);
            else send_item(MODE_FLUSH, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_frame(int w, int h, int kern, int shift, int style);
        logic [15:0] base;
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_KERNEL, kern);
        write_reg(REG_SHIFT, shift);
        base = 16'($urandom);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(19) == 0) send_item(2'd3, 16'($urandom), 8'($urandom));
            if ($urandom_range(29) == 0) send_item(MODE_FLUSH, 16'($urandom), '0);
            if ($urandom_range(39) == 0)
                send_item(MODE_LOAD, 16'($urandom_range(1, 65535)), 8'($urandom));
            send_item(MODE_PIXEL, pick_pixel(style, base), 8'($urandom));
        end
        flush_frame();
        drain();
    endtask

    task automatic test_table_load();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            send_item(MODE_LOAD, (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0001
                                 : 16'($urandom), 8'(i));
        end
        send_item(2'd3, 16'hFFFF, 8'hFF);
        drain();
    endtask

    task automatic test_tiny_frames();
        write_reg(REG_WIDTH, 32'h1FFF);
        write_reg(REG_HEIGHT, 32'h1FFF);
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_KERNEL, 31);
        write_reg(REG_SHIFT, 15);
        send_item(MODE_FLUSH, '0, '0);
        send_item(MODE_PIXEL, 16'hFFFF, 8'hFF);
        send_item(MODE_PIXEL, 16'h1234, '0);
        send_item(MODE_FLUSH, '0, '0);
        drain();
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 4096);
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        for (int i = 0; i < 6; i++) send_item(MODE_PIXEL, i[0] ? 16'hFFFF : 16'h0000, '0);
        flush_frame();
        drain();
    endtask

    task automatic test_extreme_kernels();
        idle_mode = IDLE_NONE;
        run_frame(12, 12, 21, 0, 2);
        run_frame(11, 13, 1, 0, 0);
        // zero LUT entries 0 and 1: interior pixels keep their centre unless reloaded
        send_item(MODE_LOAD, '0, 8'd0);
        send_item(MODE_LOAD, '0, 8'd1);
        run_frame(7, 7, 3, 15, 0);
        send_item(MODE_LOAD, 16'hFFFF, 8'd0);
        send_item(MODE_LOAD, 16'h8000, 8'd1);
        drain();
    endtask

    task automatic test_midframe_config();
        run_frame(9, 8, 0, 8, 1);
        write_reg(REG_KERNEL, 4);
        for (int i = 0; i < 4; i++) send_item(MODE_PIXEL, 16'($urandom), '0);
        drain();
        // geometry is locked while a frame is open; kernel and shift are not
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 3);
        write_reg(REG_KERNEL, 2);
        write_reg(REG_SHIFT, 3);
        for (int i = 4; i < 72; i++) begin
            send_item(MODE_PIXEL, 16'($urandom_range(30000, 30400)), '0);
            if (i == 40) begin
                drain();
                write_reg(REG_KERNEL, 5);
                write_reg(REG_SHIFT, 0);
            end
        end
        flush_frame();
        drain();
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        hold_off = 400;
        run_frame(16, 16, 0, 8, 0);
        idle_mode = IDLE_BOTH;
        hold_off = 300;
        run_frame(10, 10, 2, 4, 1);
    endtask

    task automatic test_random_frames();
        int w, h, kern, frame_no;
        frame_no = 0;
        while (items_sent < 1350) begin
            idle_mode = t_idle_mode'(frame_no % 4);
            w = ($urandom_range(5) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
            h = ($urandom_range(5) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 14);
            kern = ($urandom_range(7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 10);
            run_frame(w, h, kern, $urandom_range(0, 15), $urandom_range(0, 3));
            frame_no++;
        end
    endtask

    initial begin
        cfg_width = 640;
        cfg_height = 480;
        cfg_kernel = 0;
        cfg_shift = 8;
        in_col = 0;
        in_row = 0;
        out_cnt = 0;
        for (int i = 0; i < LINE_DEPTH; i++) pix_lines[i] = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) range_lut[i] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_table_load();
        test_tiny_frames();
        test_extreme_kernels();
        test_midframe_config();
        test_backpressure();
        test_random_frames();
        drain();
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("bilateral_window_filter_top regression: pass");
        end else begin
            $display("bilateral_window_filter_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bwf_pkg.sv
sv/bwf_ram.sv
sv/bwf_div_cell.sv
sv/bwf_divider.sv
sv/bilateral_window_filter_top.sv
sim/bilateral_window_filter_top_tb.sv
